// ===== rtl/dependency_language_lexer_macros.svh =====
`ifndef DEPENDENCY_LANGUAGE_LEXER_MACROS_SVH
`define DEPENDENCY_LANGUAGE_LEXER_MACROS_SVH

// checked only outside reset
`define DLL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define DLL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dll_pkg.sv =====
package dll_pkg;

  localparam int LINE_BITS_DEFAULT = 16;
  localparam logic [15:0] START_LINE_RESET = 16'd1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // token codes
  localparam logic [4:0] K_EOF       = 5'd0;
  localparam logic [4:0] K_WCHR      = 5'd16;
  localparam logic [4:0] K_WORD      = 5'd17;
  localparam logic [4:0] K_BANNER    = 5'd18;
  localparam logic [4:0] K_NEEDS     = 5'd19;
  localparam logic [4:0] K_ERR_ESC   = 5'd20;
  localparam logic [4:0] K_ERR_QUOTE = 5'd21;
  localparam logic [4:0] K_MAX       = 5'd21;

  // special characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [5:0] {
    M_START   = 6'b000001,
    M_COMMENT = 6'b000010,
    M_WORD    = 6'b000100,
    M_ESC     = 6'b001000,
    M_QUOTE   = 6'b010000,
    M_QESC    = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [7:0]  char_out;
    logic [15:0] line_no;
    logic        last;
  } out_item_t;

  typedef struct packed {
    mode_t      mode;
    logic       kw_allowed;
    logic [2:0] kw_prog;
    logic [1:0] kw_alive;   // bit 0 BANNER, bit 1 NEEDS
  } lex_state_t;

  function automatic logic [4:0] op_code(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h3A:   k = 5'd1;   // :
      8'h2B:   k = 5'd2;   // +
      8'h3D:   k = 5'd3;   // =
      8'h28:   k = 5'd4;   // (
      8'h29:   k = 5'd5;   // )
      8'h25:   k = 5'd6;   // %
      8'h2F:   k = 5'd7;   // /
      8'h3B:   k = 5'd8;   // ;
      8'h3F:   k = 5'd9;   // ?
      8'h3C:   k = 5'd10;  // <
      8'h3E:   k = 5'd11;  // >
      8'h26:   k = 5'd12;  // &
      8'h40:   k = 5'd13;  // @
      8'h2A:   k = 5'd14;  // *
      8'h24:   k = 5'd15;  // $
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] banner_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h42;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h4E;
      3'd3:    c = 8'h4E;
      3'd4:    c = 8'h45;
      3'd5:    c = 8'h52;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] needs_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h4E;
      3'd1:    c = 8'h45;
      3'd2:    c = 8'h45;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h53;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/dll_step.sv =====
module dll_step #(
  parameter int LINE_BITS = dll_pkg::LINE_BITS_DEFAULT
) (
  input  dll_pkg::lex_state_t st,
  input  logic [LINE_BITS-1:0] line,
  input  dll_pkg::in_item_t   item,
  input  logic [15:0]         start_line,
  output dll_pkg::lex_state_t st_next,
  output logic [LINE_BITS-1:0] line_next,
  output logic [1:0]          n,
  output dll_pkg::out_item_t  r0,
  output dll_pkg::out_item_t  r1
);

  typedef struct packed {
    logic       emit;
    logic [4:0] kind;
    logic [7:0] ch;
    logic       inc;
    dll_pkg::lex_state_t st;
  } sb_t;

  logic [7:0] c;
  logic [LINE_BITS-1:0] line_inc;
  logic [LINE_BITS-1:0] line_emit;
  logic [31:0] line_wide;
  logic [4:0] close_kind;
  logic       word_byte;
  dll_pkg::lex_state_t cleared;
  dll_pkg::lex_state_t tracked;
  sb_t sb;
  logic [4:0] k0, k1;
  logic [7:0] ch0, ch1;

  function automatic dll_pkg::lex_state_t kw_track(input dll_pkg::lex_state_t s,
                                                   input logic [7:0] ch);
    dll_pkg::lex_state_t r;
    r = s;
    if (s.kw_prog >= 3'd6 || dll_pkg::banner_char(s.kw_prog) != ch) r.kw_alive[0] = 1'b0;
    if (s.kw_prog >= 3'd5 || dll_pkg::needs_char(s.kw_prog) != ch) r.kw_alive[1] = 1'b0;
    if (s.kw_prog != 3'd7) r.kw_prog = s.kw_prog + 3'd1;
    return r;
  endfunction

  assign c = item.char_in;
  assign line_inc = line + LINE_BITS'(1);

  assign word_byte = !(c == dll_pkg::CH_NUL || c == dll_pkg::CH_SP || c == dll_pkg::CH_TAB ||
                       c == dll_pkg::CH_NL || c == dll_pkg::CH_HASH ||
                       c == dll_pkg::CH_QUOTE || c == dll_pkg::CH_BSLASH) &&
                     (c == dll_pkg::CH_DOLLAR || dll_pkg::op_code(c) == dll_pkg::K_EOF);

  always_comb begin
    close_kind = dll_pkg::K_WORD;
    if (st.kw_allowed) begin
      if (st.kw_alive[0] && st.kw_prog == 3'd6) close_kind = dll_pkg::K_BANNER;
      else if (st.kw_alive[1] && st.kw_prog == 3'd5) close_kind = dll_pkg::K_NEEDS;
    end
  end

  always_comb begin
    cleared = '{mode: dll_pkg::M_START, kw_allowed: 1'b1, kw_prog: 3'd0, kw_alive: 2'b11};
    tracked = kw_track(st, c);
  end

  // token start; keyword state is always clear here
  always_comb begin
    sb.emit = 1'b0;
    sb.kind = dll_pkg::K_WCHR;
    sb.ch   = 8'h00;
    sb.inc  = 1'b0;
    sb.st   = cleared;
    if (c == dll_pkg::CH_NUL || c == dll_pkg::CH_SP || c == dll_pkg::CH_TAB) begin
      sb.emit = 1'b0;
    end else if (c == dll_pkg::CH_NL) begin
      sb.inc = 1'b1;
    end else if (c == dll_pkg::CH_HASH) begin
      sb.st.mode = dll_pkg::M_COMMENT;
    end else if (dll_pkg::op_code(c) != dll_pkg::K_EOF) begin
      sb.emit = 1'b1;
      sb.kind = dll_pkg::op_code(c);
    end else if (c == dll_pkg::CH_BSLASH) begin
      sb.st.kw_allowed = 1'b0;
      sb.st.mode = dll_pkg::M_ESC;
    end else if (c == dll_pkg::CH_QUOTE) begin
      sb.st.kw_allowed = 1'b0;
      sb.st.mode = dll_pkg::M_QUOTE;
    end else begin
      sb.emit = 1'b1;
      sb.ch = c;
      sb.st = kw_track(cleared, c);
      sb.st.mode = dll_pkg::M_WORD;
    end
  end

  always_comb begin
    st_next   = st;
    line_next = line;
    line_emit = line;
    n   = 2'd0;
    k0  = dll_pkg::K_EOF;
    k1  = dll_pkg::K_EOF;
    ch0 = 8'h00;
    ch1 = 8'h00;
    if (item.is_end) begin
      n = 2'd1;
      unique case (st.mode) inside
        dll_pkg::M_WORD: begin
          k0 = close_kind;
          n  = 2'd2;
        end
        dll_pkg::M_ESC:                  k0 = dll_pkg::K_ERR_ESC;
        dll_pkg::M_QUOTE, dll_pkg::M_QESC: k0 = dll_pkg::K_ERR_QUOTE;
        default:                         k0 = dll_pkg::K_EOF;
      endcase
      st_next   = cleared;
      line_next = LINE_BITS'(start_line);
    end else begin
      unique case (st.mode) inside
        dll_pkg::M_COMMENT: begin
          if (c == dll_pkg::CH_NL) begin
            line_next = line_inc;
            st_next.mode = dll_pkg::M_START;
          end
        end
        dll_pkg::M_WORD: begin
          if (word_byte) begin
            st_next = tracked;
            n = 2'd1;
            k0 = dll_pkg::K_WCHR;
            ch0 = c;
          end else if (c == dll_pkg::CH_BSLASH) begin
            st_next.kw_allowed = 1'b0;
            st_next.mode = dll_pkg::M_ESC;
          end else if (c == dll_pkg::CH_QUOTE) begin
            st_next.kw_allowed = 1'b0;
            st_next.mode = dll_pkg::M_QUOTE;
          end else begin
            // delimiter: close the word, then treat the byte as a token start
            k0 = close_kind;
            k1 = sb.kind;
            ch1 = sb.ch;
            n = sb.emit ? 2'd2 : 2'd1;
            st_next = sb.st;
            if (sb.inc) line_next = line_inc;
          end
        end
        dll_pkg::M_ESC, dll_pkg::M_QESC: begin
          if (c == dll_pkg::CH_NL) begin
            line_next = line_inc;
            line_emit = line_inc;
          end
          st_next = tracked;
          st_next.mode = (st.mode == dll_pkg::M_ESC) ? dll_pkg::M_WORD : dll_pkg::M_QUOTE;
          n = 2'd1;
          k0 = dll_pkg::K_WCHR;
          ch0 = c;
        end
        dll_pkg::M_QUOTE: begin
          if (c == dll_pkg::CH_QUOTE) begin
            st_next.mode = dll_pkg::M_WORD;
          end else if (c == dll_pkg::CH_BSLASH) begin
            st_next.mode = dll_pkg::M_QESC;
          end else begin
            if (c == dll_pkg::CH_NL) begin
              line_next = line_inc;
              line_emit = line_inc;
            end
            st_next = tracked;
            n = 2'd1;
            k0 = dll_pkg::K_WCHR;
            ch0 = c;
          end
        end
        default: begin
          k0 = sb.kind;
          ch0 = sb.ch;
          n = sb.emit ? 2'd1 : 2'd0;
          st_next = sb.st;
          if (sb.inc) line_next = line_inc;
        end
      endcase
    end
  end

  assign line_wide = 32'(line_emit);

  always_comb begin
    r0.token_kind = k0;
    r0.char_out   = ch0;
    r0.line_no    = line_wide[15:0];
    r0.last       = (n == 2'd1);
    r1.token_kind = k1;
    r1.char_out   = ch1;
    r1.line_no    = line_wide[15:0];
    r1.last       = 1'b1;
  end

endmodule

// ===== rtl/dependency_language_lexer.sv =====
// A byte beat is registered on acceptance and lexed, once the queue has room for two
// tokens, into a four-entry result queue; its tokens are offered from that queue.
// Throughput: one byte per cycle while the queue holds two tokens or fewer; a byte
// that yields two tokens (word end plus operator, word end plus eof) pushes both at once.
// Reset: synchronous; lexer back to token start, start_line to 1, line counter to 1,
// queue emptied. No clearing pass.
module dependency_language_lexer #(
  parameter int LINE_BITS = dll_pkg::LINE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dll_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dll_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  logic [15:0] start_line;
  logic        s1_valid;
  dll_pkg::in_item_t s1_item;
  dll_pkg::lex_state_t st, st_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic [1:0] n;
  dll_pkg::out_item_t r0, r1;

  dll_pkg::out_item_t queue [dll_pkg::QDEPTH];
  logic [dll_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [dll_pkg::QCNT_W-1:0] count;
  logic fire, pop;
  logic [1:0] push_n;

  dll_step #(.LINE_BITS(LINE_BITS)) u_step (
    .st         (st),
    .line       (line),
    .item       (s1_item),
    .start_line (start_line),
    .st_next    (st_next),
    .line_next  (line_next),
    .n          (n),
    .r0         (r0),
    .r1         (r1)
  );

  // room for two tokens needed before a byte is lexed
  assign fire     = s1_valid && (count <= dll_pkg::QCNT_W'(dll_pkg::QDEPTH - 2));
  assign in_ready = !s1_valid || fire;
  assign push_n   = fire ? n : 2'd0;
  assign out_valid = (count != '0);
  assign pop      = out_valid && out_ready;
  assign out_data = queue[rd_ptr];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_line <= dll_pkg::START_LINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      start_line <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= '{mode: dll_pkg::M_START, kw_allowed: 1'b1, kw_prog: 3'd0, kw_alive: 2'b11};
      line <= LINE_BITS'(dll_pkg::START_LINE_RESET);
    end else if (fire) begin
      st   <= st_next;
      line <= line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) queue[wr_ptr] <= r0;
    if (push_n == 2'd2) queue[wr_ptr + dll_pkg::QPTR_W'(1)] <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + dll_pkg::QPTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + dll_pkg::QPTR_W'(1);
      count  <= count + dll_pkg::QCNT_W'(push_n) - dll_pkg::QCNT_W'(pop);
    end
  end

endmodule

// ===== rtl/dll_checker.sv =====
`include "dependency_language_lexer_macros.svh"

module dll_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input dll_pkg::out_item_t out_data
);

  logic term_kind;
  assign term_kind = (out_data.token_kind == dll_pkg::K_EOF) ||
                     (out_data.token_kind == dll_pkg::K_ERR_ESC) ||
                     (out_data.token_kind == dll_pkg::K_ERR_QUOTE);

  `DLL_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result beat offered after reset")

  `DLL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data),
    "stalled result beat changed")

  `DLL_ASSERT(a_kind_range, out_valid |-> out_data.token_kind <= dll_pkg::K_MAX,
    "token kind out of range")

  `DLL_ASSERT(a_char_zero,
    out_valid && out_data.token_kind != dll_pkg::K_WCHR |-> out_data.char_out == 8'h00,
    "byte on a token that is not a word char")

  `DLL_ASSERT(a_term_last, out_valid && term_kind |-> out_data.last,
    "eof or error token not last of its byte")

endmodule

bind dependency_language_lexer dll_checker u_dll_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== test/lexer_checker.sv =====
`timescale 1ns / 1ps

// Watches the byte, token and start_line channels, runs its own lexer on every
// accepted byte beat and checks each token beat against the oldest one owed.
module lexer_checker
  import dll_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          tokens_seen,
  output int          keywords_seen,
  output int          errors_seen
);

  localparam logic [4:0]      NOT_OP     = 5'd0;
  localparam logic [8*15-1:0] OP_CHARS   = ":+=()%/;?<>&@*$";
  localparam logic [47:0]     BANNER_TXT = "BANNER";
  localparam logic [39:0]     NEEDS_TXT  = "NEEDS";

  mode_t       lex_mode;
  logic        kw_ok;
  logic [2:0]  kw_cnt;
  logic [1:0]  kw_live;   // bit 0 BANNER, bit 1 NEEDS
  logic [15:0] line_cnt;
  logic [15:0] start_val;
  out_item_t   tokens_owed[$];
  out_item_t   step_toks[$];

  task automatic note_mismatch(input string what);
    $display("MISMATCH at %0t ns, token %0d: %s", $time, tokens_seen, what);
    fails++;
  endtask

  function automatic logic [4:0] op_lookup(input logic [7:0] c);
    logic [4:0] k;
    k = NOT_OP;
    for (int i = 0; i < 15; i++)
      if (OP_CHARS[8*(14-i) +: 8] == c) k = i[4:0] + 5'd1;
    return k;
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    if (c == CH_NUL || c == CH_SP || c == CH_TAB || c == CH_NL || c == CH_HASH ||
        c == CH_QUOTE || c == CH_BSLASH)
      return 1'b0;
    return c == CH_DOLLAR || op_lookup(c) == NOT_OP;
  endfunction

  task automatic push_tok(input logic [4:0] kind, input logic [7:0] ch);
    out_item_t t;
    t.token_kind = kind;
    t.char_out   = ch;
    t.line_no    = line_cnt;
    t.last       = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic kw_reset(input logic allowed);
    kw_ok   = allowed;
    kw_cnt  = 3'd0;
    kw_live = 2'b11;
  endtask

  task automatic take_char(input logic [7:0] c);
    int p;
    p = int'(kw_cnt);
    if (p >= 6 || BANNER_TXT[8*(5-(p % 6)) +: 8] != c) kw_live[0] = 1'b0;
    if (p >= 5 || NEEDS_TXT[8*(4-(p % 5)) +: 8] != c) kw_live[1] = 1'b0;
    if (p < 7) kw_cnt = kw_cnt + 3'd1;
    push_tok(K_WCHR, c);
  endtask

  task automatic close_word();
    logic [4:0] kind;
    kind = K_WORD;
    if (kw_ok) begin
      if (kw_live[0] && kw_cnt == 3'd6) kind = K_BANNER;
      else if (kw_live[1] && kw_cnt == 3'd5) kind = K_NEEDS;
    end
    kw_reset(1'b1);
    lex_mode = M_START;
    push_tok(kind, CH_NUL);
  endtask

  task automatic start_char(input logic [7:0] c);
    logic [4:0] op;
    op = op_lookup(c);
    lex_mode = M_START;
    if (!(c == CH_NUL || c == CH_SP || c == CH_TAB)) begin
      if (c == CH_NL) begin
        line_cnt = line_cnt + 16'd1;
      end else if (c == CH_HASH) begin
        lex_mode = M_COMMENT;
      end else if (op != NOT_OP) begin
        push_tok(op, CH_NUL);
      end else if (c == CH_BSLASH) begin
        kw_reset(1'b0);
        lex_mode = M_ESC;
      end else if (c == CH_QUOTE) begin
        kw_reset(1'b0);
        lex_mode = M_QUOTE;
      end else begin
        kw_reset(1'b1);
        lex_mode = M_WORD;
        take_char(c);
      end
    end
  endtask

  task automatic finish_input();
    case (lex_mode) inside
      M_WORD: begin
        close_word();
        push_tok(K_EOF, CH_NUL);
      end
      M_ESC:           push_tok(K_ERR_ESC, CH_NUL);
      M_QUOTE, M_QESC: push_tok(K_ERR_QUOTE, CH_NUL);
      default:         push_tok(K_EOF, CH_NUL);
    endcase
    lex_mode = M_START;
    kw_reset(1'b1);
    line_cnt = start_val;
  endtask

  task automatic lex_byte(input in_item_t beat);
    logic [7:0] c;
    out_item_t  t;
    c = beat.char_in;
    step_toks.delete();
    if (beat.is_end) begin
      finish_input();
    end else begin
      case (lex_mode)
        M_COMMENT: begin
          if (c == CH_NL) begin
            line_cnt = line_cnt + 16'd1;
            lex_mode = M_START;
          end
        end
        M_WORD: begin
          if (is_word_char(c)) begin
            take_char(c);
          end else if (c == CH_BSLASH) begin
            kw_ok = 1'b0;
            lex_mode = M_ESC;
          end else if (c == CH_QUOTE) begin
            kw_ok = 1'b0;
            lex_mode = M_QUOTE;
          end else begin
            // delimiter: close the word, then treat the byte as a fresh token start
            close_word();
            start_char(c);
          end
        end
        M_ESC: begin
          if (c == CH_NL) line_cnt = line_cnt + 16'd1;
          take_char(c);
          lex_mode = M_WORD;
        end
        M_QUOTE: begin
          if (c == CH_QUOTE) begin
            lex_mode = M_WORD;
          end else if (c == CH_BSLASH) begin
            lex_mode = M_QESC;
          end else begin
            if (c == CH_NL) line_cnt = line_cnt + 16'd1;
            take_char(c);
          end
        end
        M_QESC: begin
          if (c == CH_NL) line_cnt = line_cnt + 16'd1;
          take_char(c);
          lex_mode = M_QUOTE;
        end
        default: start_char(c);
      endcase
    end
    for (int i = 0; i < step_toks.size(); i++) begin
      t = step_toks[i];
      t.last = (i == step_toks.size() - 1);
      tokens_owed.push_back(t);
    end
    pending = tokens_owed.size();
  endtask

  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (tokens_owed.size() == 0) begin
      note_mismatch($sformatf("kind %0d arrived with nothing owed", got.token_kind));
      tokens_seen++;
      return;
    end
    want = tokens_owed.pop_front();
    pending = tokens_owed.size();
    if (want.token_kind == K_BANNER || want.token_kind == K_NEEDS) keywords_seen++;
    if (want.token_kind == K_ERR_ESC || want.token_kind == K_ERR_QUOTE) errors_seen++;
    if (got.token_kind != want.token_kind)
      note_mismatch($sformatf("token_kind %0d, want %0d", got.token_kind, want.token_kind));
    if (got.char_out != want.char_out)
      note_mismatch($sformatf("char_out %02h, want %02h", got.char_out, want.char_out));
    if (got.line_no != want.line_no)
      note_mismatch($sformatf("line_no %0d, want %0d", got.line_no, want.line_no));
    if (got.last != want.last)
      note_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    tokens_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start_val = START_LINE_RESET;
      line_cnt  = START_LINE_RESET;
      lex_mode  = M_START;
      kw_reset(1'b1);
      tokens_owed.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) start_val = cfg_data;
      if (in_valid && in_ready) lex_byte(in_data);
      if (out_valid && out_ready) check_beat(out_data);
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dll_pkg::*;

  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 215;
  localparam int HOLD_AFTER    = 80;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;

  localparam logic [8*15-1:0] OP_CHARS   = ":+=()%/;?<>&@*$";
  localparam logic [8*7-1:0]  KW_LETTERS = "BANERDS";
  localparam logic [8*14-1:0] MISC_CHARS = "$_.-0123456789";

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  int fails, pending, tokens_seen, keywords_seen, errors_seen;
  int bytes_sent, ends_sent, settings_used;
  bit zero_gap;
  logic [7:0] frag[$];

  always #1 clk = ~clk;

  dependency_language_lexer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lexer_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fails         (fails),
    .pending       (pending),
    .tokens_seen   (tokens_seen),
    .keywords_seen (keywords_seen),
    .errors_seen   (errors_seen)
  );

  // valid is only dropped when a gap is drawn, so back-to-back beats keep it high
  task automatic send_beat(input logic [7:0] c, input logic e);
    int gap;
    gap = zero_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_in: c, is_end: e};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_end();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    ends_sent++;
  endtask

  task automatic flush_frag();
    while (frag.size() > 0) begin
      send_beat(frag.pop_front(), 1'b0);
      bytes_sent++;
    end
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      guard++;
    end while (pending != 0 && guard < DRAIN_LIMIT);
    if (pending != 0) begin
      $display("timed out with %0d tokens outstanding", pending);
      $display("dependency_language_lexer test failed");
      $finish;
    end else begin
      // bytes that make no token may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  task automatic write_start_line(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic void add(input logic [7:0] c);
    frag.push_back(c);
  endfunction

  function automatic logic [7:0] rand_op();
    int k;
    k = $urandom_range(0, 14);
    return OP_CHARS[8*k +: 8];
  endfunction

  function automatic logic [7:0] rand_word_char();
    int k;
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: begin
        k = $urandom_range(0, 6);
        c = KW_LETTERS[8*k +: 8];
      end
      1: c = 8'h61 + 8'($urandom_range(0, 25));
      2: c = 8'h80 + 8'($urandom_range(0, 127));
      default: begin
        k = $urandom_range(0, 13);
        c = MISC_CHARS[8*k +: 8];
      end
    endcase
    return c;
  endfunction

  function automatic void add_delim();
    case ($urandom_range(0, 7)) inside
      0, 7:    add(CH_SP);
      1:       add(CH_TAB);
      2:       add(CH_NL);
      3:       add(CH_NUL);
      4, 5:    add(rand_op());
      default: ;   // run into the next fragment
    endcase
  endfunction

  function automatic void add_quoted();
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 6);
    add(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(0, 5) == 0) ? CH_NL : 8'($urandom_range(0, 255));
      if (b == CH_QUOTE || b == CH_BSLASH) begin
        add(CH_BSLASH);
        add(8'($urandom_range(0, 255)));
      end else begin
        add(b);
      end
    end
    add(CH_QUOTE);
  endfunction

  function automatic void add_keyword();
    logic [47:0] kw;
    logic [7:0]  c;
    int len, n, pos, variant;
    if ($urandom_range(0, 1)) begin
      kw  = "BANNER";
      len = 6;
    end else begin
      kw  = 48'("NEEDS");
      len = 5;
    end
    variant = $urandom_range(0, 5);
    n   = (variant == 2) ? $urandom_range(1, len - 1) : len;
    pos = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      c = kw[8*(len-1-i) +: 8];
      if (variant == 4 && i == pos) c = rand_word_char();
      if (variant == 5 && i == pos) begin
        // escaped or quoted letter spoils the keyword
        if ($urandom_range(0, 1)) begin
          add(CH_BSLASH);
          add(c);
        end else begin
          add(CH_QUOTE);
          add(c);
          add(CH_QUOTE);
        end
      end else begin
        add(c);
      end
    end
    if (variant == 3) add(rand_word_char());
    add_delim();
  endfunction

  function automatic void add_word();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          add(CH_BSLASH);
          add(8'($urandom_range(0, 255)));
        end
        1:       add_quoted();
        default: add(rand_word_char());
      endcase
    end
    add_delim();
  endfunction

  function automatic void add_comment();
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 10);
    add(CH_HASH);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      add(b == CH_NL ? CH_HASH : b);
    end
    add(CH_NL);
  endfunction

  // open construct, if any, left hanging before the end marker
  function automatic void add_open_tail();
    case ($urandom_range(0, 5))
      1: add(CH_BSLASH);
      2: begin
        add(rand_word_char());
        add(CH_BSLASH);
      end
      3: begin
        add(CH_QUOTE);
        add(rand_word_char());
      end
      4: begin
        add(CH_QUOTE);
        add(CH_BSLASH);
      end
      5: begin
        add(rand_word_char());
        add(rand_word_char());
      end
      default: ;
    endcase
  endfunction

  task automatic run_fragment();
    int sel;
    bit ends;
    sel  = $urandom_range(0, 99);
    ends = 1'b0;
    if (sel < 18) begin
      add_keyword();
    end else if (sel < 38) begin
      add_word();
    end else if (sel < 52) begin
      add(rand_op());
    end else if (sel < 62) begin
      case ($urandom_range(0, 3))
        0:       add(CH_SP);
        1:       add(CH_TAB);
        2:       add(CH_NL);
        default: add(CH_NUL);
      endcase
    end else if (sel < 70) begin
      add_comment();
    end else if (sel < 80) begin
      add_quoted();
      add_delim();
    end else if (sel < 86) begin
      add_open_tail();
      ends = 1'b1;
    end else begin
      repeat ($urandom_range(1, 4)) add(8'($urandom_range(0, 255)));
    end
    flush_frag();
    if (ends) send_end();
  endtask

  // output side: random stalls, plus one long hold so the input backs up
  initial begin : receiver
    int gap;
    int beats_taken;
    bit held;
    beats_taken = 0;
    held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = zero_gap ? 0 : $urandom_range(0, 7);
      if (!held && beats_taken >= HOLD_AFTER) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats_taken++;
    end
  end

  initial begin : stimulus
    logic [15:0] first_line;
    int mark;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // every operator at token start
    for (int i = 14; i >= 0; i--) add(OP_CHARS[8*i +: 8]);
    // dollar inside a word, escaped newline, quoted escaped newline, zero byte ends it
    add("A");
    add(CH_DOLLAR);
    add(CH_BSLASH);
    add(CH_NL);
    add(CH_QUOTE);
    add(CH_BSLASH);
    add(CH_NL);
    add(CH_QUOTE);
    add(CH_NUL);
    // top byte value, newline ending a word
    add(8'hFF);
    add(CH_NL);
    flush_frag();
    add(CH_BSLASH);
    flush_frag();
    send_end();
    add(CH_QUOTE);
    flush_frag();
    send_end();
    add("Z");
    flush_frag();
    send_end();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       first_line = 16'hFFFF;
        1:       first_line = 16'h0000;
        3:       first_line = 16'h8000;
        5:       first_line = START_LINE_RESET;
        default: first_line = 16'($urandom_range(0, 65535));
      endcase
      wait_idle();
      zero_gap = (ph == 2);
      write_start_line(first_line);
      send_end();   // reload the line counter from the new setting
      mark = bytes_sent + ends_sent;
      while (bytes_sent + ends_sent - mark < PHASE_ITEMS) run_fragment();
    end
    zero_gap = 1'b0;
    wait_idle();

    $display("Summary: %0d bytes and %0d end markers over %0d start_line values",
             bytes_sent, ends_sent, settings_used);
    $display("Summary: %0d tokens checked, %0d keywords, %0d error tokens, %0d mismatches",
             tokens_seen, keywords_seen, errors_seen, fails);
    if (fails == 0)
      $display("dependency_language_lexer test passed");
    else
      $display("dependency_language_lexer test failed");
    $finish;
  end

  initial begin : run_limit
    #1_000_000;
    $display("run limit reached");
    $display("dependency_language_lexer test failed");
    $finish;
  end

endmodule
